FILE: hdl/lcbs_pkg.sv
// Package: types, constants and helper functions for LDPC code block segmentation.
`default_nettype none

package lcbs_pkg;

   // Maximum code block sizes and per-block CRC length
   localparam logic [13:0] KCB_GRAPH1 = 14'd8448;
   localparam logic [13:0] KCB_GRAPH2 = 14'd3840;
   localparam logic [4:0]  CRC_LEN    = 5'd24;

   // Information columns
   localparam logic [4:0] KB_GRAPH1    = 5'd22;
   localparam logic [4:0] KB_GRAPH2_10 = 5'd10;
   localparam logic [4:0] KB_GRAPH2_9  = 5'd9;
   localparam logic [4:0] KB_GRAPH2_8  = 5'd8;
   localparam logic [4:0] KB_GRAPH2_6  = 5'd6;

   // Graph 2 column thresholds on B
   localparam logic [20:0] KB_THRESH_HI  = 21'd640;
   localparam logic [20:0] KB_THRESH_MID = 21'd560;
   localparam logic [20:0] KB_THRESH_LO  = 21'd192;

   localparam logic [1:0] GRAPH_ONE = 2'd1;

   // Lifting size limits
   localparam logic [9:0] ZC_MIN = 10'd2;
   localparam logic [9:0] ZC_DIRECT_MAX = 10'd16;
   localparam logic [9:0] ZC_MAX = 10'd384;

   // Divider chain geometry
   localparam int unsigned REM_W     = 24;
   localparam int unsigned CNT_Q_W   = 10;  // block count quotient
   localparam int unsigned CNT_DEN_W = 14;
   localparam int unsigned KP_Q_W    = 14;  // bits per block quotient
   localparam int unsigned KP_DEN_W  = 10;
   localparam int unsigned Z_Q_W     = 9;   // min lifting size quotient
   localparam int unsigned Z_DEN_W   = 5;
   localparam int unsigned Z_REM_W   = 14;

   typedef struct packed {
      logic [20:0] tb_bits;
      logic [1:0]  base_graph;
   } lcbs_req_type;

   typedef struct packed {
      logic [7:0]  num_blocks;
      logic [13:0] block_bits;
      logic [8:0]  lifting_size;
      logic [13:0] filler_bits;
      logic [4:0]  systematic_cols;
      logic [13:0] payload_bits;
   } lcbs_rsp_type;

   // Context carried alongside the block count division
   typedef struct packed {
      logic [20:0] tb_bits;
      logic        graph1;
      logic        multi;
      logic [4:0]  kb;
   } lcbs_cnt_side_type;

   // Context carried alongside the bits-per-block division
   typedef struct packed {
      logic        graph1;
      logic        multi;
      logic [4:0]  kb;
      logic [9:0]  blocks;
   } lcbs_kp_side_type;

   // Context carried alongside the lifting size division
   typedef struct packed {
      logic        graph1;
      logic        multi;
      logic [4:0]  kb;
      logic [9:0]  blocks;
      logic [13:0] kp;
   } lcbs_z_side_type;

   // Smallest standard lifting size at least z, saturating at 384
   function automatic logic [8:0] lcbs_lift_round(input logic [8:0] z);
      logic [9:0] zw;
      logic [9:0] rnd;
      zw  = {1'b0, z};
      rnd = zw;
      if (zw <= ZC_MIN) begin
         rnd = ZC_MIN;
      end else if (zw <= ZC_DIRECT_MAX) begin
         rnd = zw;
      end else if (zw > ZC_MAX) begin
         rnd = ZC_MAX;
      end else if (zw <= 10'd32) begin
         rnd = (zw + 10'd1) & ~10'd1;
      end else if (zw <= 10'd64) begin
         rnd = (zw + 10'd3) & ~10'd3;
      end else if (zw <= 10'd128) begin
         rnd = (zw + 10'd7) & ~10'd7;
      end else if (zw <= 10'd256) begin
         rnd = (zw + 10'd15) & ~10'd15;
      end else begin
         rnd = (zw + 10'd31) & ~10'd31;
      end
      return rnd[8:0];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/ldpc_code_block_segmentation_params.sv
// Top level: NR LDPC code block segmentation parameter pipeline.
//
// Takes a transport block size B (CRC included) and a base graph number and
// returns the code block count C, block length K, lifting size Zc, filler
// count F, information columns Kb and data bits per block (K' less the
// per-block CRC). Base graph 1 selects Kcb = 8448; any other code is graph 2
// with Kcb = 3840. C saturates at 255 on the port while every other field
// reflects the true count. The work is three rows of restoring-division cells
// in series: C = ceil(B / (Kcb - 24)) over 10 cells, K' = floor(B' / C) over
// 14 cells, and ceil(K' / Kb) over 9 cells, followed by the output register
// that rounds to a standard lifting size and forms K and F. One transaction
// is accepted every cycle while req_stall is low. Each cell holds its data
// while the next one is full and stalled, so bubbles in the pipeline are
// squeezed out and req_stall only rises once the whole pipeline, all three
// rows and the output register, is backed up behind a stalled result.
`default_nettype none

module ldpc_code_block_segmentation_params (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire lcbs_pkg::lcbs_req_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lcbs_pkg::lcbs_rsp_type     rsp_data
);

   import lcbs_pkg::*;

   localparam int unsigned CNT_SIDE_W = $bits(lcbs_cnt_side_type);
   localparam int unsigned KP_SIDE_W  = $bits(lcbs_kp_side_type);
   localparam int unsigned Z_SIDE_W   = $bits(lcbs_z_side_type);

   // ---------------- front: block count division setup ----------------
   logic              graph1;
   logic [13:0]       kcb;
   logic [13:0]       cnt_den;
   logic [REM_W-1:0]  cnt_num;
   logic [4:0]        kb;
   lcbs_cnt_side_type cnt_side;
   logic              cnt_in_ready;

   always_comb begin
      graph1  = (req_data.base_graph == GRAPH_ONE);
      kcb     = graph1 ? KCB_GRAPH1 : KCB_GRAPH2;
      cnt_den = kcb - 14'(CRC_LEN);
      // ceil via (B + d - 1) / d
      cnt_num = REM_W'(req_data.tb_bits) + REM_W'(cnt_den) - REM_W'(1);
      priority if (graph1) begin
         kb = KB_GRAPH1;
      end else if (req_data.tb_bits > KB_THRESH_HI) begin
         kb = KB_GRAPH2_10;
      end else if (req_data.tb_bits > KB_THRESH_MID) begin
         kb = KB_GRAPH2_9;
      end else if (req_data.tb_bits > KB_THRESH_LO) begin
         kb = KB_GRAPH2_8;
      end else begin
         kb = KB_GRAPH2_6;
      end
      cnt_side.tb_bits = req_data.tb_bits;
      cnt_side.graph1  = graph1;
      cnt_side.multi   = (req_data.tb_bits > 21'(kcb));
      cnt_side.kb      = kb;
   end

   assign req_stall = !cnt_in_ready;

   logic                  cnt_out_valid;
   logic                  cnt_out_ready;
   logic [CNT_Q_W-1:0]    cnt_quo;
   logic [CNT_SIDE_W-1:0] cnt_out_vec;

   lcbs_div_chain #(
      .REM_W  (REM_W),
      .DEN_W  (CNT_DEN_W),
      .Q_W    (CNT_Q_W),
      .SIDE_W (CNT_SIDE_W)
   ) u_cnt_chain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (cnt_in_ready),
      .in_num    (cnt_num),
      .in_den    (cnt_den),
      .in_side   (cnt_side),
      .out_valid (cnt_out_valid),
      .out_ready (cnt_out_ready),
      .out_quo   (cnt_quo),
      .out_side  (cnt_out_vec)
   );

   // ---------------- K' = floor(B' / C) setup ----------------
   lcbs_cnt_side_type cnt_res;
   logic [9:0]        blocks;
   logic [REM_W-1:0]  kp_num;
   lcbs_kp_side_type  kp_side;

   always_comb begin
      cnt_res = lcbs_cnt_side_type'(cnt_out_vec);
      blocks  = cnt_res.multi ? cnt_quo : 10'd1;
      // B' = B + 24*C, CRC bits only when segmented
      kp_num  = REM_W'(cnt_res.tb_bits);
      if (cnt_res.multi) begin
         kp_num = kp_num + (REM_W'(blocks) << 4) + (REM_W'(blocks) << 3);
      end
      kp_side.graph1 = cnt_res.graph1;
      kp_side.multi  = cnt_res.multi;
      kp_side.kb     = cnt_res.kb;
      kp_side.blocks = blocks;
   end

   logic                 kp_out_valid;
   logic                 kp_out_ready;
   logic [KP_Q_W-1:0]    kp_quo;
   logic [KP_SIDE_W-1:0] kp_out_vec;

   lcbs_div_chain #(
      .REM_W  (REM_W),
      .DEN_W  (KP_DEN_W),
      .Q_W    (KP_Q_W),
      .SIDE_W (KP_SIDE_W)
   ) u_kp_chain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cnt_out_valid),
      .in_ready  (cnt_out_ready),
      .in_num    (kp_num),
      .in_den    (blocks),
      .in_side   (kp_side),
      .out_valid (kp_out_valid),
      .out_ready (kp_out_ready),
      .out_quo   (kp_quo),
      .out_side  (kp_out_vec)
   );

   // ---------------- ceil(K' / Kb) setup ----------------
   lcbs_kp_side_type    kp_res;
   logic [Z_REM_W-1:0]  z_num;
   lcbs_z_side_type     z_side;

   always_comb begin
      kp_res = lcbs_kp_side_type'(kp_out_vec);
      // Kb >= 6, so no underflow even for K' = 0
      z_num  = Z_REM_W'(kp_quo) + Z_REM_W'(kp_res.kb) - Z_REM_W'(1);
      z_side.graph1 = kp_res.graph1;
      z_side.multi  = kp_res.multi;
      z_side.kb     = kp_res.kb;
      z_side.blocks = kp_res.blocks;
      z_side.kp     = kp_quo;
   end

   logic                z_out_valid;
   logic                z_out_ready;
   logic [Z_Q_W-1:0]    z_quo;
   logic [Z_SIDE_W-1:0] z_out_vec;

   lcbs_div_chain #(
      .REM_W  (Z_REM_W),
      .DEN_W  (Z_DEN_W),
      .Q_W    (Z_Q_W),
      .SIDE_W (Z_SIDE_W)
   ) u_z_chain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (kp_out_valid),
      .in_ready  (kp_out_ready),
      .in_num    (z_num),
      .in_den    (kp_res.kb),
      .in_side   (z_side),
      .out_valid (z_out_valid),
      .out_ready (z_out_ready),
      .out_quo   (z_quo),
      .out_side  (z_out_vec)
   );

   // ---------------- output register: Zc, K, F ----------------
   lcbs_z_side_type z_res;
   logic [8:0]      zc;
   logic [13:0]     zc_w;
   logic [13:0]     k_len;
   lcbs_rsp_type    rsp_in;
   lcbs_rsp_type    rsp_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;

   always_comb begin
      z_res = lcbs_z_side_type'(z_out_vec);
      zc    = lcbs_lift_round(z_quo);
      zc_w  = 14'(zc);
      // K = 22*Zc or 10*Zc
      if (z_res.graph1) begin
         k_len = (zc_w << 4) + (zc_w << 2) + (zc_w << 1);
      end else begin
         k_len = (zc_w << 3) + (zc_w << 1);
      end
      rsp_in.num_blocks      = (z_res.blocks > 10'd255) ? 8'd255 : z_res.blocks[7:0];
      rsp_in.block_bits      = k_len;
      rsp_in.lifting_size    = zc;
      rsp_in.filler_bits     = (k_len >= z_res.kp) ? (k_len - z_res.kp) : 14'd0;
      rsp_in.systematic_cols = z_res.kb;
      rsp_in.payload_bits    = z_res.multi ? (z_res.kp - 14'(CRC_LEN)) : z_res.kp;
      z_out_ready  = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = z_out_ready ? z_out_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (z_out_valid && z_out_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/lcbs_div_cell.sv
// One restoring-division cell: resolves a single quotient bit and registers it.
`default_nettype none

module lcbs_div_cell #(
   parameter int unsigned REM_W  = 24,
   parameter int unsigned DEN_W  = 14,
   parameter int unsigned Q_W    = 10,
   parameter int unsigned SHIFT  = 0,
   parameter int unsigned SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              up_valid,
   output logic                   up_ready,
   input  wire logic [REM_W-1:0]  up_rem,
   input  wire logic [DEN_W-1:0]  up_den,
   input  wire logic [Q_W-1:0]    up_quo,
   input  wire logic [SIDE_W-1:0] up_side,
   output logic                   dn_valid,
   input  wire logic              dn_ready,
   output logic [REM_W-1:0]       dn_rem,
   output logic [DEN_W-1:0]       dn_den,
   output logic [Q_W-1:0]         dn_quo,
   output logic [SIDE_W-1:0]      dn_side
);

   logic              valid_ff;
   logic              valid_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [SIDE_W-1:0] side_ff;
   logic [REM_W-1:0]  den_sh;
   logic              fits;
   logic              load;

   always_comb begin
      den_sh   = REM_W'(up_den) << SHIFT;
      fits     = (up_rem >= den_sh);
      rem_in   = fits ? (up_rem - den_sh) : up_rem;
      quo_in   = up_quo | (fits ? (Q_W'(1) << SHIFT) : '0);
      up_ready = !valid_ff || dn_ready;
      load     = up_valid && up_ready;
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_in;
         den_ff  <= up_den;
         quo_ff  <= quo_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_den   = den_ff;
   assign dn_quo   = quo_ff;
   assign dn_side  = side_ff;

endmodule

`default_nettype wire

FILE: hdl/lcbs_div_chain.sv
// Row of division cells, one quotient bit per cell, most significant first.
`default_nettype none

module lcbs_div_chain #(
   parameter int unsigned REM_W  = 24,
   parameter int unsigned DEN_W  = 14,
   parameter int unsigned Q_W    = 10,
   parameter int unsigned SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [REM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [Q_W-1:0]         out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   logic              stage_valid [Q_W+1];
   logic              stage_ready [Q_W+1];
   logic [REM_W-1:0]  stage_rem   [Q_W+1];
   logic [DEN_W-1:0]  stage_den   [Q_W+1];
   logic [Q_W-1:0]    stage_quo   [Q_W+1];
   logic [SIDE_W-1:0] stage_side  [Q_W+1];

   assign stage_valid[0] = in_valid;
   assign stage_rem[0]   = in_num;
   assign stage_den[0]   = in_den;
   assign stage_quo[0]   = '0;
   assign stage_side[0]  = in_side;
   assign in_ready       = stage_ready[0];

   for (genvar i = 0; i < Q_W; i++) begin : g_cell
      lcbs_div_cell #(
         .REM_W  (REM_W),
         .DEN_W  (DEN_W),
         .Q_W    (Q_W),
         .SHIFT  (Q_W - 1 - i),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[i]),
         .up_ready (stage_ready[i]),
         .up_rem   (stage_rem[i]),
         .up_den   (stage_den[i]),
         .up_quo   (stage_quo[i]),
         .up_side  (stage_side[i]),
         .dn_valid (stage_valid[i+1]),
         .dn_ready (stage_ready[i+1]),
         .dn_rem   (stage_rem[i+1]),
         .dn_den   (stage_den[i+1]),
         .dn_quo   (stage_quo[i+1]),
         .dn_side  (stage_side[i+1])
      );
   end

   assign stage_ready[Q_W] = out_ready;
   assign out_valid        = stage_valid[Q_W];
   assign out_quo          = stage_quo[Q_W];
   assign out_side         = stage_side[Q_W];

endmodule

`default_nettype wire
